FILE: rtl/c39_pkg.sv
// Shared types, constants and symbol tables for the Code 39 symbol encoder.
package c39_pkg;

  localparam int unsigned SymIdxW    = 6;
  localparam int unsigned ElemCntW   = 4;
  localparam int unsigned RunWidthW  = 6;
  localparam int unsigned NarrowW    = 4;
  localparam int unsigned SymElems   = 9;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [SymIdxW-1:0]   AsteriskIdx = 6'd39;
  localparam logic [ElemCntW-1:0]  GapElem     = 4'd9;
  localparam logic [ElemCntW-1:0]  LastBarElem = 4'd8;

  typedef enum logic [1:0] {
    PH_START,
    PH_DATA,
    PH_STOP
  } phase_e;

  // One classified request handed from the front end to the run generator.
  typedef struct packed {
    logic               bad;
    logic               start;
    logic               stop;
    logic [SymIdxW-1:0] idx;
  } job_t;

  typedef struct packed {
    logic               ok;
    logic [SymIdxW-1:0] idx;
  } lookup_t;

  // Maps an ASCII code to its symbol index; '*' is reserved and reported as bad.
  function automatic lookup_t char_lookup(input logic [7:0] ch);
    lookup_t r;
    r.ok  = 1'b1;
    r.idx = '0;
    priority if (ch >= 8'h30 && ch <= 8'h39) begin
      r.idx = SymIdxW'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      r.idx = SymIdxW'(ch - 8'h41 + 8'd10);
    end else if (ch == 8'h2D) begin
      r.idx = 6'd36;
    end else if (ch == 8'h2E) begin
      r.idx = 6'd37;
    end else if (ch == 8'h20) begin
      r.idx = 6'd38;
    end else if (ch == 8'h24) begin
      r.idx = 6'd40;
    end else if (ch == 8'h2F) begin
      r.idx = 6'd41;
    end else if (ch == 8'h2B) begin
      r.idx = 6'd42;
    end else if (ch == 8'h25) begin
      r.idx = 6'd43;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Wide/narrow mask per symbol, first element in the MSB, 1 = wide.
  function automatic logic [SymElems-1:0] sym_pattern(input logic [SymIdxW-1:0] idx);
    logic [SymElems-1:0] p;
    unique case (idx)
      6'd0:  p = 9'b000110100;
      6'd1:  p = 9'b100100001;
      6'd2:  p = 9'b001100001;
      6'd3:  p = 9'b101100000;
      6'd4:  p = 9'b000110001;
      6'd5:  p = 9'b100110000;
      6'd6:  p = 9'b001110000;
      6'd7:  p = 9'b000100101;
      6'd8:  p = 9'b100100100;
      6'd9:  p = 9'b001100100;
      6'd10: p = 9'b100001001;
      6'd11: p = 9'b001001001;
      6'd12: p = 9'b101001000;
      6'd13: p = 9'b000011001;
      6'd14: p = 9'b100011000;
      6'd15: p = 9'b001011000;
      6'd16: p = 9'b000001101;
      6'd17: p = 9'b100001100;
      6'd18: p = 9'b001001100;
      6'd19: p = 9'b000011100;
      6'd20: p = 9'b100000011;
      6'd21: p = 9'b001000011;
      6'd22: p = 9'b101000010;
      6'd23: p = 9'b000010011;
      6'd24: p = 9'b100010010;
      6'd25: p = 9'b001010010;
      6'd26: p = 9'b000000111;
      6'd27: p = 9'b100000110;
      6'd28: p = 9'b001000110;
      6'd29: p = 9'b000010110;
      6'd30: p = 9'b110000001;
      6'd31: p = 9'b011000001;
      6'd32: p = 9'b111000000;
      6'd33: p = 9'b010010001;
      6'd34: p = 9'b110010000;
      6'd35: p = 9'b011010000;
      6'd36: p = 9'b010000101;
      6'd37: p = 9'b110000100;
      6'd38: p = 9'b011000100;
      6'd39: p = 9'b010010100;
      6'd40: p = 9'b010101000;
      6'd41: p = 9'b010100010;
      6'd42: p = 9'b010001010;
      6'd43: p = 9'b000101010;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/code39_symbol_encoder_unit.sv
// Top level of the Code 39 symbol encoder: front end, request queue, run generator.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one ASCII character per request,
//   with message_end_i marking the last character of a message.
//   Output channel (out_valid_o/out_ready_i) gives one bar or space run per
//   request: is_bar_o, run_width_o, bad_character_o and last_o on the final
//   run caused by an input character.
//   Config channel (cfg_valid_i/cfg_ready_o) writes narrow_width; it is
//   always ready and should only be written while the block is idle.
//   A good character makes 10 runs, 20 with the start symbol at the head of a
//   message, 30 with the stop symbol too; a bad one makes a single error run.
//   The run generator emits one run per cycle while out_ready_i holds high;
//   an accepted character goes into the queue before its first run is registered.
//   A two-entry queue lets the next characters be accepted while runs drain.
//   Reset sets narrow_width to 1 and clears the message state and queue.
//   When the receiver stalls, the output run holds and the queue fills, after
//   which in_ready_o drops.
module code39_symbol_encoder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      character_i,
  input  logic                            message_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_bar_o,
  output logic [c39_pkg::RunWidthW-1:0]   run_width_o,
  output logic                            bad_character_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [c39_pkg::NarrowW-1:0]     cfg_data_i
);

  logic [c39_pkg::NarrowW-1:0] narrow_width_q, narrow_width_d;
  logic                        push, full, pop, empty;
  c39_pkg::job_t               job_in, job_head;

  assign cfg_ready_o    = 1'b1;
  assign narrow_width_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : narrow_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_width_q <= c39_pkg::NarrowW'(1);
    end else begin
      narrow_width_q <= narrow_width_d;
    end
  end

  c39_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .character_i   (character_i),
    .message_end_i (message_end_i),
    .push_o        (push),
    .job_o         (job_in),
    .full_i        (full)
  );

  c39_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_head)
  );

  c39_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .narrow_width_i  (narrow_width_q),
    .empty_i         (empty),
    .job_i           (job_head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_bar_o        (is_bar_o),
    .run_width_o     (run_width_o),
    .bad_character_o (bad_character_o),
    .last_o          (last_o)
  );

endmodule

FILE: rtl/c39_front.sv
// Front end: accepts characters, classifies them and tracks the message state.
module c39_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          character_i,
  input  logic                message_end_i,
  output logic                push_o,
  output c39_pkg::job_t       job_o,
  input  logic                full_i
);

  c39_pkg::lookup_t lk;
  logic             in_message_q, in_message_d;
  logic             accept;

  assign lk         = c39_pkg::char_lookup(character_i);
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    job_o.bad   = !lk.ok;
    job_o.start = !in_message_q;
    job_o.stop  = message_end_i;
    job_o.idx   = lk.idx;
  end

  always_comb begin
    in_message_d = in_message_q;
    if (accept) begin
      in_message_d = lk.ok && !message_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_message_q <= 1'b0;
    end else begin
      in_message_q <= in_message_d;
    end
  end

endmodule

FILE: rtl/c39_fifo.sv
// Short request queue between the front end and the run generator.
module c39_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  c39_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output c39_pkg::job_t job_o
);

  c39_pkg::job_t                         mem_q [c39_pkg::QueueDepth];
  logic [c39_pkg::QueuePtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [c39_pkg::QueuePtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [c39_pkg::QueueCntW-1:0]         cnt_q, cnt_d;
  logic                                  do_push, do_pop;

  assign full_o  = (cnt_q == c39_pkg::QueueCntW'(c39_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/c39_back.sv
// Run generator: walks start, data and stop symbols, one run per cycle unless stalled.
module c39_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [c39_pkg::NarrowW-1:0]     narrow_width_i,
  input  logic                            empty_i,
  input  c39_pkg::job_t                   job_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_bar_o,
  output logic [c39_pkg::RunWidthW-1:0]   run_width_o,
  output logic                            bad_character_o,
  output logic                            last_o
);

  c39_pkg::phase_e                        phase_q, phase_d, phase;
  logic                                   active_q, active_d;
  logic [c39_pkg::ElemCntW-1:0]           elem_q, elem_d;
  logic                                   out_valid_q, out_valid_d;
  logic                                   is_bar_q, bad_q, last_q;
  logic [c39_pkg::RunWidthW-1:0]          width_q;
  logic                                   load;
  logic [c39_pkg::SymIdxW-1:0]            sym;
  logic [c39_pkg::SymElems-1:0]           pat;
  logic [c39_pkg::RunWidthW-1:0]          narrow, wide;
  logic                                   gap, wide_el, run_last;
  logic                                   is_bar_n, bad_n, last_n;
  logic [c39_pkg::RunWidthW-1:0]          width_n;

  assign load   = !empty_i && (!out_valid_q || out_ready_i);
  assign narrow = c39_pkg::RunWidthW'(narrow_width_i);
  assign wide   = (narrow << 1) + narrow;

  always_comb begin
    if (active_q) begin
      phase = phase_q;
    end else if (job_i.start) begin
      phase = c39_pkg::PH_START;
    end else begin
      phase = c39_pkg::PH_DATA;
    end
  end

  assign sym      = (phase == c39_pkg::PH_DATA) ? job_i.idx : c39_pkg::AsteriskIdx;
  assign pat      = c39_pkg::sym_pattern(sym);
  assign gap      = (elem_q == c39_pkg::GapElem);
  assign wide_el  = !gap && pat[c39_pkg::LastBarElem - elem_q];
  assign run_last = gap && ((phase == c39_pkg::PH_STOP) ||
                            (phase == c39_pkg::PH_DATA && !job_i.stop));

  always_comb begin
    if (job_i.bad) begin
      is_bar_n = 1'b0;
      width_n  = '0;
      bad_n    = 1'b1;
      last_n   = 1'b1;
    end else begin
      is_bar_n = !gap && !elem_q[0];
      width_n  = wide_el ? wide : narrow;
      bad_n    = 1'b0;
      last_n   = run_last;
    end
  end

  assign pop_o = load && last_n;

  always_comb begin
    phase_d     = phase_q;
    active_d    = active_q;
    elem_d      = elem_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (last_n) begin
        active_d = 1'b0;
        elem_d   = '0;
      end else if (gap) begin
        active_d = 1'b1;
        elem_d   = '0;
        phase_d  = (phase == c39_pkg::PH_START) ? c39_pkg::PH_DATA : c39_pkg::PH_STOP;
      end else begin
        active_d = 1'b1;
        elem_d   = elem_q + 1'b1;
        phase_d  = phase;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= c39_pkg::PH_START;
      active_q    <= 1'b0;
      elem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      active_q    <= active_d;
      elem_q      <= elem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_bar_q <= is_bar_n;
      width_q  <= width_n;
      bad_q    <= bad_n;
      last_q   <= last_n;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_bar_o        = is_bar_q;
  assign run_width_o     = width_q;
  assign bad_character_o = bad_q;
  assign last_o          = last_q;

endmodule
